// File: src/fixed_block_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shorthand for clocked property checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FBPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa check failed");

// next-cycle implication
`define FBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa check failed");

`endif

// File: src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared sizes, operation and status codes, and the free stack request.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int POINTER_BYTES = 8;
    localparam int NODE_BYTES    = 8;

    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int LVL_W     = IDX_W + 1;
    localparam int ADDR_W    = 32;
    localparam int BSIZE_W   = 16;
    localparam int ALIGN_W   = 16;
    localparam int STRIDE_W  = 17;
    localparam int SPAN_W    = STRIDE_W + LVL_W;
    localparam int PROD_W    = STRIDE_W + IDX_W;
    localparam int CFG_IDX_W = 3;
    localparam int LOG2_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2   = 3'd4;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REFILL = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NULL    = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_BADCFG  = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             refill;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] wdata;
        logic [LVL_W-1:0] total;
    } t_stk_req;

endpackage

// File: src/fbpa_stack.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator free stack
// Index memory plus a low-water mark that stands in for the refill pattern.
// ----------------------------------------------------------------------------
module fbpa_stack import fbpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stk_req         i_req,
    output logic [IDX_W-1:0] o_rdata
);

    logic [IDX_W-1:0] r_mem [MAX_BLOCKS];
    logic [IDX_W-1:0] r_rdata;
    logic [IDX_W-1:0] r_fill_val;
    logic             r_pick_fill;
    logic [LVL_W-1:0] r_low;
    logic [LVL_W-1:0] r_fill_total;
    logic [LVL_W-1:0] w_pos;

    assign w_pos = {1'b0, i_req.idx};

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[i_req.idx] <= i_req.wdata;
        end
        if (i_req.pop) begin
            r_rdata     <= r_mem[i_req.idx];
            r_pick_fill <= (w_pos < r_low);
            r_fill_val  <= IDX_W'(r_fill_total - LVL_W'(1) - w_pos);
        end
    end

    // entries below the mark still hold the pattern of the last refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= '0;
            r_fill_total <= '0;
        end else if (i_req.refill) begin
            r_low        <= i_req.total;
            r_fill_total <= i_req.total;
        end else if (i_req.pop && (w_pos < r_low)) begin
            r_low <= w_pos;
        end
    end

    assign o_rdata = r_pick_fill ? r_fill_val : r_rdata;

endmodule

// File: src/fbpa_div.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator divider
// Restoring divider, one quotient bit per cycle over the 32-bit offset.
// ----------------------------------------------------------------------------
module fbpa_div import fbpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ADDR_W-1:0]   i_dividend,
    input  logic [STRIDE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [IDX_W-1:0]    o_quot,
    output logic                o_rem_zero
);

    localparam int CNT_W = $clog2(ADDR_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_W - 1);

    logic [ADDR_W-1:0]   r_quot;
    logic [STRIDE_W-1:0] r_rem;
    logic [STRIDE_W-1:0] r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [STRIDE_W:0]   w_shift;
    logic [STRIDE_W:0]   w_diff;
    logic                w_ge;
    logic [STRIDE_W-1:0] n_rem;

    assign w_shift = {r_rem, r_quot[ADDR_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[STRIDE_W-1:0] : w_shift[STRIDE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ADDR_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quot     = r_quot[IDX_W-1:0];
    assign o_rem_zero = (r_rem == '0);

endmodule

// File: src/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Pool of equal blocks with a LIFO stack of free block indices.
// ----------------------------------------------------------------------------
// One item at a time: the input is ready only while the sequencer is idle.
// Every item first passes the geometry, span, bound and check states, which derive
// and check the pool geometry from the registers. Allocate then reads the stack,
// multiplies the index by the stride and adds the start; reset pool, no-op and
// rejected items go from the check state straight to the output.
// A free that passes the range check runs the 32-step restoring divider that
// turns the offset into a block index.
// While the output is stalled, a result waits in the done state.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [ADDR_W-1:0]    i_block_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [ADDR_W-1:0]    o_alloc_address,
    output logic [LVL_W-1:0]     o_free_blocks,
    output logic [LVL_W-1:0]     o_used_blocks
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GEOM  = 9'b000000010,
        S_SPAN  = 9'b000000100,
        S_BOUND = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_POP   = 9'b001000000,
        S_ADDR  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    localparam logic [ADDR_W:0] END_LIMIT = {1'b1, {ADDR_W{1'b0}}};

    // configuration
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_pool;
    logic [BSIZE_W-1:0] r_bsize;
    logic [LVL_W-1:0]   r_total;
    logic [LOG2_W-1:0]  r_align;

    // sequencer and item
    t_state             r_state, n_state;
    t_op                r_op;
    logic [ADDR_W-1:0]  r_addr_in;
    logic [LVL_W-1:0]   r_level, n_level;
    t_status            r_status, n_status;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;

    // geometry
    logic [STRIDE_W-1:0] r_stride;
    logic [ALIGN_W-1:0]  r_adjust;
    logic [ADDR_W:0]     r_start;
    logic                r_okpre;
    logic [SPAN_W-1:0]   r_span;
    logic [ADDR_W:0]     r_end;
    logic                r_ok;
    logic [PROD_W-1:0]   r_prod;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [LVL_W-1:0]    r_out_free;
    logic [LVL_W-1:0]    r_out_used;

    logic [ALIGN_W-1:0]  w_align;
    logic [ALIGN_W-1:0]  w_amask;
    logic [BSIZE_W-1:0]  w_need;
    logic [STRIDE_W-1:0] w_stride;
    logic [ALIGN_W-1:0]  w_mis;
    logic [ALIGN_W-1:0]  w_adjust;
    logic                w_okpre;
    logic [ADDR_W:0]     w_end;
    logic [ADDR_W:0]     w_room;
    logic [ADDR_W:0]     w_addr_x;
    logic                w_load;

    t_stk_req            w_stk_req;
    logic [IDX_W-1:0]    w_stk_rdata;
    logic                w_div_start;
    logic                w_div_done;
    logic [IDX_W-1:0]    w_div_quot;
    logic                w_div_rem_zero;

    // ---- configuration port ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pool  <= '0;
            r_bsize <= '0;
            r_total <= '0;
            r_align <= LOG2_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_ADDRESS: r_base  <= i_cfg_wdata;
                CFG_POOL_BYTES:   r_pool  <= i_cfg_wdata;
                CFG_BLOCK_SIZE:   r_bsize <= i_cfg_wdata[BSIZE_W-1:0];
                CFG_BLOCK_TOTAL:  r_total <= i_cfg_wdata[LVL_W-1:0];
                CFG_ALIGN_LOG2:   r_align <= i_cfg_wdata[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- geometry ----
    assign w_align  = ALIGN_W'(1) << r_align;
    assign w_amask  = w_align - ALIGN_W'(1);
    assign w_need   = (r_bsize < BSIZE_W'(NODE_BYTES)) ? BSIZE_W'(NODE_BYTES) : r_bsize;
    assign w_stride = (STRIDE_W'(w_need) + STRIDE_W'(w_amask)) & ~STRIDE_W'(w_amask);
    assign w_mis    = r_base[ALIGN_W-1:0] & w_amask;
    assign w_adjust = (w_mis == '0) ? '0 : (w_align - w_mis);
    assign w_okpre  = (r_base != '0) && (r_pool != '0) && (r_bsize != '0) &&
                      (r_total != '0) && (r_total <= LVL_W'(MAX_BLOCKS)) &&
                      (w_align >= ALIGN_W'(POINTER_BYTES)) &&
                      (ADDR_W'(w_adjust) < r_pool);

    assign w_end    = r_start + (ADDR_W+1)'(r_span);
    assign w_room   = {1'b0, r_pool} - (ADDR_W+1)'(r_adjust);
    assign w_addr_x = {1'b0, r_addr_in};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_GEOM: begin
                r_stride <= w_stride;
                r_adjust <= w_adjust;
                r_start  <= {1'b0, r_base} + (ADDR_W+1)'(w_adjust);
                r_okpre  <= w_okpre;
            end
            S_SPAN: begin
                r_span <= {{LVL_W{1'b0}}, r_stride} * {{STRIDE_W{1'b0}}, r_total};
            end
            S_BOUND: begin
                r_end <= w_end;
                r_ok  <= r_okpre && (w_room >= (ADDR_W+1)'(r_span)) && (w_end <= END_LIMIT);
            end
            S_POP: begin
                r_prod <= {{STRIDE_W{1'b0}}, w_stk_rdata} * {{IDX_W{1'b0}}, r_stride};
            end
            default: ;
        endcase
    end

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        w_stk_req   = '0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_GEOM;
                end
            end
            S_GEOM:  n_state = S_SPAN;
            S_SPAN:  n_state = S_BOUND;
            S_BOUND: n_state = S_CHECK;
            S_CHECK: begin
                n_status   = ST_OK;
                n_res_addr = '0;
                n_state    = S_DONE;
                if (!r_ok) begin
                    n_status = ST_BADCFG;
                end else begin
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_level == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_level       = r_level - LVL_W'(1);
                                w_stk_req.pop = 1'b1;
                                w_stk_req.idx = n_level[IDX_W-1:0];
                                n_state       = S_POP;
                            end
                        end
                        OP_FREE: begin
                            if (r_addr_in == '0) begin
                                n_status = ST_NULL;
                            end else if ((w_addr_x < r_start) || (w_addr_x >= r_end)) begin
                                n_status = ST_OUTSIDE;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        OP_REFILL: begin
                            w_stk_req.refill = 1'b1;
                            w_stk_req.total  = r_total;
                            n_level          = r_total;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                    if (!w_div_rem_zero) begin
                        n_status = ST_OUTSIDE;
                    end else if (r_level >= LVL_W'(MAX_BLOCKS)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_stk_req.push  = 1'b1;
                        w_stk_req.idx   = r_level[IDX_W-1:0];
                        w_stk_req.wdata = w_div_quot;
                        n_level         = r_level + LVL_W'(1);
                    end
                end
            end
            S_POP:  n_state = S_ADDR;
            S_ADDR: begin
                n_res_addr = r_start[ADDR_W-1:0] + ADDR_W'(r_prod);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_res_addr <= n_res_addr;
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op      <= t_op'(i_op);
            r_addr_in <= i_block_address;
        end
        if (w_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_res_addr;
            r_out_free   <= r_level;
            r_out_used   <= (r_level > r_total) ? '0 : (r_total - r_level);
        end
    end

    fbpa_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stk_req),
        .o_rdata (w_stk_rdata)
    );

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_addr_in - r_start[ADDR_W-1:0]),
        .i_divisor  (r_stride),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem_zero (w_div_rem_zero)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_alloc_address = r_out_addr;
    assign o_free_blocks   = r_out_free;
    assign o_used_blocks   = r_out_used;

endmodule

// File: src/fbpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker import fbpa_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [ADDR_W-1:0]    i_cfg_wdata,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [1:0]           i_op,
    input logic [ADDR_W-1:0]    i_block_address,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [2:0]           o_status,
    input logic [ADDR_W-1:0]    o_alloc_address,
    input logic [LVL_W-1:0]     o_free_blocks,
    input logic [LVL_W-1:0]     o_used_blocks
);

    `FBPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_alloc_address))
    `FBPA_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `FBPA_ASSERT_SAME(a_addr_only_on_ok, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_alloc_address == '0)
    `FBPA_ASSERT_SAME(a_free_bound, i_clk, i_rst_n, o_out_valid, o_free_blocks <= LVL_W'(MAX_BLOCKS))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

// File: tb/sv/fbpa_pool_check.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator result checker
// Mirrors register writes and accepted items, predicts each result from its
// own copy of the pool geometry and free index stack, and compares every
// returned result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module fbpa_pool_check import fbpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_op,
    input  logic [ADDR_W-1:0]    i_block_address,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [2:0]           i_status,
    input  logic [ADDR_W-1:0]    i_alloc_address,
    input  logic [LVL_W-1:0]     i_free_blocks,
    input  logic [LVL_W-1:0]     i_used_blocks,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [LVL_W-1:0]  free_n;
        logic [LVL_W-1:0]  used_n;
    } t_pool_result;

    typedef struct packed {
        logic        ok;
        logic [63:0] start;
        logic [63:0] stride;
        logic [63:0] span;
    } t_pool_geom;

    logic [ADDR_W-1:0]  cfg_base;
    logic [ADDR_W-1:0]  cfg_pool;
    logic [BSIZE_W-1:0] cfg_bsize;
    logic [LVL_W-1:0]   cfg_total;
    logic [LOG2_W-1:0]  cfg_align_log2;

    logic [IDX_W-1:0]   idx_stack [MAX_BLOCKS];
    logic [LVL_W-1:0]   stack_level;

    t_pool_result       expected_q [$];

    function automatic t_pool_geom pool_geometry();
        t_pool_geom  g;
        logic [63:0] align;
        logic [63:0] need;
        logic [63:0] misalign;
        logic [63:0] adjust;
        g.ok     = 1'b0;
        g.start  = '0;
        g.stride = 64'd1;
        g.span   = '0;
        if (cfg_base == 0 || cfg_pool == 0 || cfg_bsize == 0 || cfg_total == 0)
            return g;
        if (cfg_total > MAX_BLOCKS)
            return g;
        align = 64'd1 << cfg_align_log2;
        if (align < POINTER_BYTES)
            return g;
        need     = (cfg_bsize < NODE_BYTES) ? 64'(NODE_BYTES) : 64'(cfg_bsize);
        g.stride = (need + align - 64'd1) & ~(align - 64'd1);
        misalign = 64'(cfg_base) & (align - 64'd1);
        adjust   = (misalign == 0) ? 64'd0 : align - misalign;
        if (adjust >= 64'(cfg_pool))
            return g;
        g.span = g.stride * 64'(cfg_total);
        if (64'(cfg_pool) - adjust < g.span)
            return g;
        g.start = 64'(cfg_base) + adjust;
        if (g.start + g.span > 64'h1_0000_0000)
            return g;
        g.ok = 1'b1;
        return g;
    endfunction

    function automatic t_pool_result apply_pool_op(t_op op, logic [ADDR_W-1:0] addr);
        t_pool_result r;
        t_pool_geom   g;
        logic [63:0]  a;
        g        = pool_geometry();
        a        = 64'(addr);
        r.status = ST_OK;
        r.addr   = '0;
        if (!g.ok) begin
            r.status = ST_BADCFG;
        end else begin
            case (op)
                OP_ALLOC: begin
                    if (stack_level == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        stack_level = stack_level - LVL_W'(1);
                        r.addr = 32'(g.start + 64'(idx_stack[stack_level[IDX_W-1:0]]) * g.stride);
                    end
                end
                OP_FREE: begin
                    if (a == 0)
                        r.status = ST_NULL;
                    else if (a < g.start || a >= g.start + g.span ||
                             ((a - g.start) % g.stride) != 0)
                        r.status = ST_OUTSIDE;
                    else if (stack_level >= MAX_BLOCKS)
                        r.status = ST_FULL;
                    else begin
                        idx_stack[stack_level[IDX_W-1:0]] = IDX_W'((a - g.start) / g.stride);
                        stack_level = stack_level + LVL_W'(1);
                    end
                end
                OP_REFILL: begin
                    for (int k = 0; k < cfg_total; k++)
                        idx_stack[IDX_W'(k)] = IDX_W'(cfg_total - 1 - k);
                    stack_level = cfg_total;
                end
                default: ;
            endcase
        end
        r.free_n = stack_level;
        r.used_n = (stack_level > cfg_total) ? '0 : cfg_total - stack_level;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pool_result exp_r;
        if (!i_rst_n) begin
            cfg_base       = '0;
            cfg_pool       = '0;
            cfg_bsize      = '0;
            cfg_total      = '0;
            cfg_align_log2 = 4'd3;
            stack_level    = '0;
            expected_q.delete();
            o_fail_count   = 0;
            o_pending      = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ADDRESS: cfg_base       = i_cfg_wdata;
                    CFG_POOL_BYTES:   cfg_pool       = i_cfg_wdata;
                    CFG_BLOCK_SIZE:   cfg_bsize      = i_cfg_wdata[BSIZE_W-1:0];
                    CFG_BLOCK_TOTAL:  cfg_total      = i_cfg_wdata[LVL_W-1:0];
                    CFG_ALIGN_LOG2:   cfg_align_log2 = i_cfg_wdata[LOG2_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: status %0d addr %h free %0d used %0d",
                                 i_status, i_alloc_address, i_free_blocks, i_used_blocks);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_status !== exp_r.status || i_alloc_address !== exp_r.addr ||
                        i_free_blocks !== exp_r.free_n || i_used_blocks !== exp_r.used_n) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"result mismatch: expected status %0d addr %h free %0d ",
                                      "used %0d, got status %0d addr %h free %0d used %0d"},
                                     exp_r.status, exp_r.addr, exp_r.free_n, exp_r.used_n,
                                     i_status, i_alloc_address, i_free_blocks, i_used_blocks);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(apply_pool_op(t_op'(i_op), i_block_address));
            o_pending = expected_q.size();
        end
    end

endmodule

// File: tb/sv/fixed_block_pool_allocator_test.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Directed checks of bad configurations, empty and full stack, free address
// rejects and double frees, then random pool configurations with mostly
// well-formed allocate/free traffic, random gaps and output stalls.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int ITEM_TARGET    = 1600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [ADDR_W-1:0]    i_cfg_wdata     = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_op            = OP_ALLOC;
    logic [ADDR_W-1:0]    i_block_address = '0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [2:0]           o_status;
    logic [ADDR_W-1:0]    o_alloc_address;
    logic [LVL_W-1:0]     o_free_blocks;
    logic [LVL_W-1:0]     o_used_blocks;

    int                   fail_count;
    int                   pending_n;
    int                   items_sent  = 0;
    int                   idle_cycles = 0;
    int                   src_mode    = 0;

    // geometry of the current pool, used to aim frees at real blocks
    logic [63:0]          pool_start  = 64'h1000;
    logic [63:0]          pool_stride = 64'd8;
    logic [63:0]          pool_span   = 64'd8;
    int                   pool_blocks = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fixed_block_pool_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_block_address (i_block_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_alloc_address (o_alloc_address),
        .o_free_blocks   (o_free_blocks),
        .o_used_blocks   (o_used_blocks)
    );

    fbpa_pool_check pool_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_block_address (i_block_address),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_alloc_address (o_alloc_address),
        .i_free_blocks   (o_free_blocks),
        .i_used_blocks   (o_used_blocks),
        .o_fail_count    (fail_count),
        .o_pending       (pending_n)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output back-pressure: calm stretches alternate with stall-heavy ones
    initial begin : sink_ctl
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode       = 0;
        mode_left  = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (mode != 0 && $urandom_range(0, 99) < ((mode == 1) ? 20 : 50)) begin
                stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(1, 3);
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_mode == 0 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_op            = op;
        i_block_address = addr;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_n != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
    endtask

    // junk above a register's width is dropped by the block
    task automatic load_pool(input logic [31:0] base, input logic [31:0] pool,
                             input logic [15:0] bsize, input logic [8:0] total,
                             input logic [3:0] alog);
        logic [31:0] junk;
        drain();
        junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
        cfg_write(CFG_BASE_ADDRESS, base);
        cfg_write(CFG_POOL_BYTES, pool);
        cfg_write(CFG_BLOCK_SIZE, {junk[31:16], bsize});
        cfg_write(CFG_BLOCK_TOTAL, {junk[31:9], total});
        cfg_write(CFG_ALIGN_LOG2, {junk[31:4], alog});
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic pick_pool();
        logic [63:0] align;
        logic [63:0] need;
        logic [63:0] stride;
        logic [63:0] span;
        logic [63:0] start;
        logic [63:0] base;
        logic [63:0] adjust;
        logic [63:0] pool;
        logic [15:0] bsize;
        logic [8:0]  total;
        logic [3:0]  alog;
        int          pick;
        alog = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(7, 15))
                                           : 4'($urandom_range(3, 6));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            bsize = 16'hFFFF;
        else if (pick < 5)
            bsize = 16'($urandom_range(1, 4096));
        else
            bsize = 16'($urandom_range(1, 64));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            total = 9'($urandom_range(200, 256));
        else if (pick < 4)
            total = 9'($urandom_range(1, 40));
        else
            total = 9'($urandom_range(1, 8));
        align  = 64'd1 << alog;
        need   = (bsize < NODE_BYTES) ? 64'(NODE_BYTES) : 64'(bsize);
        stride = (need + align - 64'd1) & ~(align - 64'd1);
        span   = stride * 64'(total);
        if ($urandom_range(0, 7) == 0)
            start = 64'h1_0000_0000 - span;
        else
            start = (64'($urandom) % (64'h1_0000_0001 - span)) & ~(align - 64'd1);
        if (start == 0)
            start = align;
        base   = start - 64'($urandom_range(0, 32'(align - 64'd1)));
        adjust = start - base;
        pick   = $urandom_range(0, 9);
        if (pick < 4)
            pool = adjust + span;
        else if (pick == 4)
            pool = 64'hFFFF_FFFF;
        else
            pool = adjust + span + 64'($urandom_range(1, 4096));
        if (pool > 64'hFFFF_FFFF)
            pool = 64'hFFFF_FFFF;
        pool_start  = start;
        pool_stride = stride;
        pool_span   = span;
        pool_blocks = int'(total);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 8))
                0: base = 64'd0;
                1: pool = 64'd0;
                2: bsize = 16'd0;
                3: total = 9'd0;
                4: total = 9'($urandom_range(257, 511));
                5: alog = 4'($urandom_range(0, 2));
                6: pool = adjust + span - 64'd1;
                7: begin
                    base = start - 64'd1;
                    pool = 64'd1;
                end
                default: begin
                    base = 64'h1_0000_0000 - span + 64'd1;
                    pool = 64'hFFFF_FFFF;
                end
            endcase
        end
        load_pool(32'(base), 32'(pool), bsize, total, alog);
    endtask

    task automatic send_random_item(input int alloc_pct);
        logic [63:0] blk;
        int          r;
        r   = $urandom_range(0, 99);
        blk = pool_start + 64'($urandom_range(0, pool_blocks - 1)) * pool_stride;
        if (r < alloc_pct) begin
            send_item(OP_ALLOC, $urandom);
        end else if (r < 90) begin
            send_item(OP_FREE, 32'(blk));
        end else if (r < 95) begin
            case ($urandom_range(0, 4))
                0: send_item(OP_FREE, '0);
                1: send_item(OP_FREE, 32'(blk + 64'($urandom_range(1, 32'(pool_stride) - 1))));
                2: send_item(OP_FREE, 32'(pool_start - 64'($urandom_range(1, 64))));
                3: send_item(OP_FREE, 32'(pool_start + pool_span));
                default: send_item(OP_FREE, $urandom);
            endcase
        end else if (r < 98) begin
            send_item(OP_REFILL, $urandom);
        end else begin
            send_item(OP_NOP, $urandom);
        end
    endtask

    initial begin : stimulus
        int n;
        int alloc_pct;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers still at reset: every op reports a bad configuration
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, 32'hFFFF_FFFF);
        send_item(OP_REFILL, '0);
        send_item(OP_NOP, '0);

        // three 8-byte blocks from 0x1008, region sized exactly
        load_pool(32'h0000_1001, 32'd31, 16'd3, 9'd3, 4'd3);
        send_item(OP_ALLOC, '0);
        send_item(OP_REFILL, '0);
        repeat (4) send_item(OP_ALLOC, 32'hFFFF_FFFF);
        send_item(OP_FREE, '0);
        send_item(OP_FREE, 32'h0000_1000);
        send_item(OP_FREE, 32'h0000_1020);
        send_item(OP_FREE, 32'h0000_100C);
        send_item(OP_FREE, 32'hFFFF_FFFF);
        send_item(OP_FREE, 32'h0000_1010);
        send_item(OP_FREE, 32'h0000_1010);
        send_item(OP_FREE, 32'h0000_1008);
        send_item(OP_FREE, 32'h0000_1018);
        send_item(OP_NOP, '0);
        send_item(OP_ALLOC, '0);

        // largest blocks, full pool: a free onto a full stack is dropped
        load_pool(32'h1000_0000, 32'hFFFF_FFFF, 16'hFFFF, 9'd256, 4'd12);
        send_item(OP_REFILL, '0);
        send_item(OP_FREE, 32'h1000_0000);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, 32'h10FF_0000);

        // top of address space overflows; then alignment above 12
        load_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd8, 9'd1, 4'd15);
        send_item(OP_NOP, '0);
        load_pool(32'h8000_0001, 32'h0001_7FFF, 16'd100, 9'd2, 4'd15);
        send_item(OP_REFILL, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);

        while (items_sent < ITEM_TARGET) begin
            src_mode = $urandom_range(0, 3);
            pick_pool();
            if ($urandom_range(0, 4) != 0)
                send_item(OP_REFILL, $urandom);
            n         = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(10, 60);
            alloc_pct = $urandom_range(20, 70);
            repeat (n) send_random_item(alloc_pct);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/fbpa_pkg.sv
src/fbpa_stack.sv
src/fbpa_div.sv
src/fixed_block_pool_allocator.sv
src/fbpa_checker.sv
tb/sv/fbpa_pool_check.sv
tb/sv/fixed_block_pool_allocator_test.sv
